>>> rtl/ellipsoid_surface_normal_macros.svh
// ----------------------------------------------------------------------------
// Ellipsoid surface normal: assertion macros
// Concurrent checks that disappear in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ELLIPSOID_SURFACE_NORMAL_MACROS_SVH
`define ELLIPSOID_SURFACE_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ESN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("esn assertion failed");
// next-cycle implication
`define ESN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("esn assertion failed");
`else
`define ESN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ESN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/esn_pkg.sv
// ----------------------------------------------------------------------------
// Ellipsoid surface normal: package
// Shared widths, reset values, register indexes and the sqrt sideband type.
// ----------------------------------------------------------------------------
package esn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NFB_DEF         = 15;
    localparam int WEIGHT_W        = 18;
    localparam int A_W             = 31;   // normalized magnitude, largest in [2^30, 2^31)
    localparam int SQ_W            = 64;   // sum of squares
    localparam int ROOT_W          = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_X_RST = 18'd130195;
    localparam logic [WEIGHT_W-1:0] WEIGHT_Y_RST = 18'd130195;
    localparam logic [WEIGHT_W-1:0] WEIGHT_Z_RST = 18'd131072;

    typedef enum logic [1:0] {
        CFG_WEIGHT_X = 2'd0,
        CFG_WEIGHT_Y = 2'd1,
        CFG_WEIGHT_Z = 2'd2
    } t_cfg_idx;

    // travels alongside the square root pipeline
    typedef struct packed {
        logic [2:0][A_W-1:0] a;
        logic [2:0]          neg;
        logic                zero;
    } t_side;

endpackage

>>> rtl/esn_isqrt.sv
// ----------------------------------------------------------------------------
// Ellipsoid surface normal: pipelined integer square root
// One result bit per stage, floor(sqrt) of a 64-bit value, sideband carried.
// ----------------------------------------------------------------------------
module esn_isqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_rad,
    input  esn_pkg::t_side i_side,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output esn_pkg::t_side o_side
);
    import esn_pkg::*;

    logic              w_v    [0:ROOT_W];
    logic [SQ_W-1:0]   w_rem  [0:ROOT_W];
    logic [SQ_W-1:0]   w_res  [0:ROOT_W];
    t_side             w_side [0:ROOT_W];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_rad;
    assign w_res[0]  = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic            r_v;
        logic [SQ_W-1:0] r_rem, r_res;
        t_side           r_side;
        logic [SQ_W-1:0] n_rem, n_res, w_try;

        always_comb begin
            w_try = w_res[k] + BIT;
            if (w_rem[k] >= w_try) begin
                n_rem = w_rem[k] - w_try;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_rem = w_rem[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_res  <= n_res;
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_res[k+1]  = r_res;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[ROOT_W];
    assign o_root  = w_res[ROOT_W][ROOT_W-1:0];
    assign o_side  = w_side[ROOT_W];

endmodule

>>> rtl/ellipsoid_surface_normal.sv
// ----------------------------------------------------------------------------
// Ellipsoid surface normal
// Weights a position per axis and scales it to a unit normal in Q1.F.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                                   Content
// s         in   i_s_tvalid o_s_tready i_s_tdata           pos_x, pos_y, pos_z
// m         out  o_m_tvalid i_m_tready o_m_tdata o_m_tuser normal_x/y/z, zero_vector
// cfg       in   i_cfg_valid o_cfg_ready i_cfg_index/data  weight_x/y/z
//
// One item per cycle while the output is not stalled. Items pass the front
// stages, the 32-stage square root and the one-bit-per-stage divider. The
// whole pipeline advances together; it holds while a result sits unread in
// the output register. Reset clears valid bits and loads the weights.
// ----------------------------------------------------------------------------
`include "ellipsoid_surface_normal_macros.svh"

module ellipsoid_surface_normal #(
    parameter int  COORD_WIDTH      = esn_pkg::COORD_WIDTH_DEF,
    parameter int  NORMAL_FRAC_BITS = esn_pkg::NFB_DEF,
    localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * (NORMAL_FRAC_BITS + 1) + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [IN_W-1:0]              i_s_tdata,   // pos_x, pos_y, pos_z
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_W-1:0]             o_m_tdata,   // normal_x, normal_y, normal_z
    output logic                         o_m_tuser,   // zero_vector
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [esn_pkg::WEIGHT_W-1:0] i_cfg_data
);
    import esn_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int NFB  = NORMAL_FRAC_BITS;
    localparam int NW   = NFB + 1;
    localparam int PW   = CW + WEIGHT_W;
    localparam int LW   = $clog2(PW + 1);
    localparam int RW   = A_W + NFB + 2;
    localparam int NDIV = NFB + 1;
    localparam logic [NW-1:0] LIMIT = {1'b0, {NFB{1'b1}}};

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;
    assign o_cfg_ready = 1'b1;

    // configuration
    logic [WEIGHT_W-1:0] r_weight [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0] <= WEIGHT_X_RST;
            r_weight[1] <= WEIGHT_Y_RST;
            r_weight[2] <= WEIGHT_Z_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WEIGHT_X: r_weight[0] <= i_cfg_data;
                CFG_WEIGHT_Y: r_weight[1] <= i_cfg_data;
                CFG_WEIGHT_Z: r_weight[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits of the front stages
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6} <= '0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    logic [CW-1:0]      r1_mag [3];
    logic [2:0]         r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;
    logic [PW-1:0]      r2_prod [3];
    logic [PW-1:0]      r3_prod [3];
    logic [LW-1:0]      r3_len;
    logic [A_W-1:0]     r4_a [3];
    logic [A_W-1:0]     r5_a [3];
    logic               r4_zero, r5_zero;
    logic [2*A_W-1:0]   r5_sq [3];
    logic [SQ_W-1:0]    r6_sum;
    t_side              r6_side;

    logic [PW-1:0]      w_or;
    logic [LW-1:0]      n_len;

    always_comb begin
        w_or  = r2_prod[0] | r2_prod[1] | r2_prod[2];
        n_len = '0;
        for (int b = 0; b < PW; b++) begin
            if (w_or[b]) n_len = LW'(b + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                // stage 1: magnitude
                r1_neg[c] <= i_s_tdata[c*CW + CW - 1];
                r1_mag[c] <= i_s_tdata[c*CW + CW - 1] ? (~i_s_tdata[c*CW +: CW] + CW'(1))
                                                       : i_s_tdata[c*CW +: CW];
                // stage 2: weight
                r2_prod[c] <= PW'(r1_mag[c]) * PW'(r_weight[c]);
                // stage 3: length of largest
                r3_prod[c] <= r2_prod[c];
                // stage 4: common shift so the largest sits in [2^30, 2^31)
                r4_a[c] <= A_W'({r3_prod[c], A_W'(0)} >> r3_len);
                // stage 5: squares
                r5_sq[c] <= (2*A_W)'(r4_a[c]) * (2*A_W)'(r4_a[c]);
                r5_a[c]  <= r4_a[c];
            end
            r2_neg  <= r1_neg;
            r3_neg  <= r2_neg;
            r3_len  <= n_len;
            r4_neg  <= r3_neg;
            r4_zero <= (r3_len == '0);
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
            // stage 6: sum of squares
            r6_sum  <= SQ_W'(r5_sq[0]) + SQ_W'(r5_sq[1]) + SQ_W'(r5_sq[2]);
            r6_side.a[0] <= r5_a[0];
            r6_side.a[1] <= r5_a[1];
            r6_side.a[2] <= r5_a[2];
            r6_side.neg  <= r5_neg;
            r6_side.zero <= r5_zero;
        end
    end

    logic          w_sq_valid;
    logic [31:0]   w_root;
    t_side         w_sq_side;

    esn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_rad   (r6_sum),
        .i_side  (r6_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // rounded division, one quotient bit per stage, MSB first
    logic              w_dv    [0:NDIV];
    logic [RW-1:0]     w_drem  [0:NDIV][3];
    logic [NW-1:0]     w_dq    [0:NDIV][3];
    logic [ROOT_W-1:0] w_droot [0:NDIV];
    logic [2:0]        w_dneg  [0:NDIV];
    logic              w_dzero [0:NDIV];

    assign w_dv[0]    = w_sq_valid;
    assign w_droot[0] = w_root;
    assign w_dneg[0]  = w_sq_side.neg;
    assign w_dzero[0] = w_sq_side.zero;
    for (genvar c = 0; c < 3; c++) begin : g_dinit
        assign w_drem[0][c] = (RW'(w_sq_side.a[c]) << NFB) + RW'(w_root >> 1);
        assign w_dq[0][c]   = '0;
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int J = NFB - k;
        logic              r_v;
        logic [RW-1:0]     r_rem [3];
        logic [NW-1:0]     r_q   [3];
        logic [ROOT_W-1:0] r_root;
        logic [2:0]        r_neg;
        logic              r_zero;
        logic [RW-1:0]     w_dvs;

        assign w_dvs = RW'(w_droot[k]) << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int c = 0; c < 3; c++) begin
                    if (w_drem[k][c] >= w_dvs) begin
                        r_rem[c] <= w_drem[k][c] - w_dvs;
                        r_q[c]   <= w_dq[k][c] | (NW'(1) << J);
                    end else begin
                        r_rem[c] <= w_drem[k][c];
                        r_q[c]   <= w_dq[k][c];
                    end
                end
                r_root <= w_droot[k];
                r_neg  <= w_dneg[k];
                r_zero <= w_dzero[k];
            end
        end

        assign w_dv[k+1]    = r_v;
        assign w_droot[k+1] = r_root;
        assign w_dneg[k+1]  = r_neg;
        assign w_dzero[k+1] = r_zero;
        for (genvar c = 0; c < 3; c++) begin : g_lane
            assign w_drem[k+1][c] = r_rem[c];
            assign w_dq[k+1][c]   = r_q[c];
        end
    end

    // output register: clamp, sign, zero case
    logic                r_out_valid;
    logic [3*NW-1:0]     r_out_data;
    logic                r_out_zero;
    logic [3*NW-1:0]     n_out_data;

    always_comb begin
        logic [NW-1:0] mag;
        for (int c = 0; c < 3; c++) begin
            mag = (w_dq[NDIV][c] > LIMIT) ? LIMIT : w_dq[NDIV][c];
            if (w_dzero[NDIV]) begin
                n_out_data[c*NW +: NW] = '0;
            end else if (w_dneg[NDIV][c]) begin
                n_out_data[c*NW +: NW] = ~mag + NW'(1);
            end else begin
                n_out_data[c*NW +: NW] = mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_zero <= w_dzero[NDIV];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);
    assign o_m_tuser  = r_out_zero;

    // the largest square lands in the top two bits
    logic [2*A_W-1:0] w_sq_or;
    assign w_sq_or = r5_sq[0] | r5_sq[1] | r5_sq[2];

    `ESN_ASSERT_IMP(a_zero_out, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, r_out_data == '0)
    `ESN_ASSERT_IMP(a_root_range, i_clk, i_rst_n, w_sq_valid && !w_sq_side.zero, |w_root[31:30])
    `ESN_ASSERT_NXT(a_sq_norm, i_clk, i_rst_n, w_en && r_v4 && !r4_zero, |w_sq_or[2*A_W-1 -: 2])

endmodule
